// File: src/stpr_pkg.sv
// Shared types and constants for the stepper axis ramp controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stpr_pkg;

    // command codes carried in the func field
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_MOVEABS = 3'd1;
    localparam logic [2:0] FUNC_MOVEREL = 3'd2;
    localparam logic [2:0] FUNC_STOP    = 3'd3;
    localparam logic [2:0] FUNC_ENABLE  = 3'd4;
    localparam logic [2:0] FUNC_DISABLE = 3'd5;
    localparam logic [2:0] FUNC_ZERO    = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_TARGET_SPEED = 2'd0;
    localparam logic [1:0] CFG_ACCELERATION = 2'd1;
    localparam logic [1:0] CFG_STEPS_UNIT   = 2'd2;

    localparam logic [23:0] SPEED_FLOOR = 24'd2560;  // 10.0 in Q16.8
    localparam logic [63:0] US_PER_S    = 64'd1000000;

    // x / 1e6 == ((x >> 6) * R) >> 48 for x < 2^40, R = ceil(2^48 / 15625);
    // R is split as RECIP_HI * 2^24 + RECIP_LO to fit the 24-bit multiplier port
    localparam logic [23:0] RECIP_LO = 24'd12445742;
    localparam logic [23:0] RECIP_HI = 24'd1073;

    // shared multiply unit
    localparam logic MDU_MUL = 1'b0;  // acc = a * b
    localparam logic MDU_MAC = 1'b1;  // acc = (previous acc >> 24) + a * b

    localparam logic [4:0] LEN_ELAPSED = 5'd16;  // accel * elapsed_us
    localparam logic [4:0] LEN_RCP_LO  = 5'd24;  // y * RECIP_LO
    localparam logic [4:0] LEN_RCP_HI  = 5'd11;  // y * RECIP_HI, RECIP_HI < 2^11
    localparam logic [4:0] LEN_ACCEL   = 5'd24;  // remaining * accel
    localparam logic [4:0] LEN_SPEED   = 5'd24;  // speed * speed
    localparam logic [4:0] LEN_SPU     = 5'd16;  // speed^2 * steps_per_unit

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] value;
        logic [15:0]        elapsed_us;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic               step_pulse;
        logic               direction;
        logic signed [31:0] position;
        logic [23:0]        speed;
        logic               moving;
        logic               enabled;
        logic               homed;
    } out_t;

    typedef struct packed {
        logic [23:0] target_speed;
        logic [23:0] acceleration;
        logic [15:0] steps_per_unit;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] a;
        logic [23:0] b;
        logic [4:0]  len;
    } mdu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } mdu_rsp_t;

endpackage

// File: src/stpr_mdu.sv
// Bit-serial shift-add multiplier built around one 64-bit adder; the MAC form
// adds the high part of the previous product. Depends on stpr_pkg.
`timescale 1ns / 1ps

module stpr_mdu import stpr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mdu_req_t req,
    output mdu_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [63:0] a_reg;
    logic [23:0] b_reg;

    logic [63:0] sum;

    // acc += a when b[0]
    assign sum = acc_reg + (b_reg[0] ? a_reg : 64'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.len;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            // MAC seeds the sum with the previous product's bits from 24 up
            acc_reg <= (req.op == MDU_MAC) ? (acc_reg >> 24) : 64'd0;
            a_reg   <= req.a;
            b_reg   <= req.b;
        end else if (busy_reg) begin
            acc_reg <= sum;
            a_reg   <= a_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// File: src/stpr_ctrl.sv
// Command sequencer and axis state: decodes commands, drives the shared
// multiply unit through the ramp math, commits state. Depends on stpr_pkg.
`timescale 1ns / 1ps

module stpr_ctrl import stpr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_t      s_data,
    input  cfg_t     cfg,
    output logic     res_valid,
    input  logic     res_ready,
    output out_t     res_data,
    output mdu_req_t mdu_req,
    input  mdu_rsp_t mdu_rsp
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHG_MUL = 3'd1;
    localparam logic [2:0] ST_RCP_LO  = 3'd2;
    localparam logic [2:0] ST_RCP_HI  = 3'd3;
    localparam logic [2:0] ST_REM_MUL = 3'd4;
    localparam logic [2:0] ST_SQ_MUL  = 3'd5;
    localparam logic [2:0] ST_SPU_MUL = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  func_reg;
    logic [31:0] value_reg;
    logic [33:0] y_reg;
    logic [20:0] change_reg;
    logic [56:0] lhs_reg;
    logic [54:0] rhs_reg;

    logic [31:0] pos_reg, tgt_reg;
    logic [23:0] spd_reg;
    logic        moving_reg, enabled_reg, homed_reg;

    logic [31:0] pos_next, tgt_next;
    logic [23:0] spd_next;
    logic        moving_next, enabled_next, homed_next;
    logic        accepted, pulse, dir;

    logic [32:0] delta;
    logic [32:0] remaining;
    logic        tick_go;
    logic        commit;
    logic        decel;
    logic [24:0] floor_sum;
    logic [24:0] up_sum;
    logic [24:0] down_diff;

    assign delta     = {tgt_reg[31], tgt_reg} - {pos_reg[31], pos_reg};
    assign remaining = delta[32] ? (33'd0 - delta) : delta;
    assign tick_go   = (s_data.func == FUNC_TICK) && moving_reg && enabled_reg
                       && (cfg.acceleration != 24'd0);
    assign s_ready   = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign commit    = res_valid && res_ready;

    // sequencer and unit requests
    always_comb begin
        state_next = state_reg;
        mdu_req    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (tick_go) begin
                        mdu_req.start = 1'b1;
                        mdu_req.op    = MDU_MUL;
                        mdu_req.a     = {40'd0, cfg.acceleration};
                        mdu_req.b     = {8'd0, s_data.elapsed_us};
                        mdu_req.len   = LEN_ELAPSED;
                        state_next    = ST_CHG_MUL;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CHG_MUL: begin
                // x / 1e6 by reciprocal: low half of R first, on y = x >> 6
                if (mdu_rsp.done) begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_MUL;
                    mdu_req.a     = {30'd0, mdu_rsp.result[39:6]};
                    mdu_req.b     = RECIP_LO;
                    mdu_req.len   = LEN_RCP_LO;
                    state_next    = ST_RCP_LO;
                end
            end
            ST_RCP_LO: begin
                if (mdu_rsp.done) begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_MAC;
                    mdu_req.a     = {30'd0, y_reg};
                    mdu_req.b     = RECIP_HI;
                    mdu_req.len   = LEN_RCP_HI;
                    state_next    = ST_RCP_HI;
                end
            end
            ST_RCP_HI: begin
                if (mdu_rsp.done) begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_MUL;
                    mdu_req.a     = {31'd0, remaining};
                    mdu_req.b     = cfg.acceleration;
                    mdu_req.len   = LEN_ACCEL;
                    state_next    = ST_REM_MUL;
                end
            end
            ST_REM_MUL: begin
                if (mdu_rsp.done) begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_MUL;
                    mdu_req.a     = {40'd0, spd_reg};
                    mdu_req.b     = spd_reg;
                    mdu_req.len   = LEN_SPEED;
                    state_next    = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                if (mdu_rsp.done) begin
                    mdu_req.start = 1'b1;
                    mdu_req.op    = MDU_MUL;
                    mdu_req.a     = {16'd0, mdu_rsp.result[47:0]};
                    mdu_req.b     = {8'd0, cfg.steps_per_unit};
                    mdu_req.len   = LEN_SPU;
                    state_next    = ST_SPU_MUL;
                end
            end
            ST_SPU_MUL: begin
                if (mdu_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // next axis state for the held command
    always_comb begin
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        spd_next     = spd_reg;
        moving_next  = moving_reg;
        enabled_next = enabled_reg;
        homed_next   = homed_reg;
        accepted     = 1'b0;
        pulse        = 1'b0;
        dir          = 1'b0;
        decel        = ({2'd0, lhs_reg} <= {4'd0, rhs_reg});
        floor_sum    = {1'b0, SPEED_FLOOR} + {4'd0, change_reg};
        up_sum       = {1'b0, spd_reg} + {4'd0, change_reg};
        down_diff    = {1'b0, spd_reg} - {4'd0, change_reg};
        case (func_reg)
            FUNC_TICK: begin
                if (moving_reg && enabled_reg) begin
                    accepted = 1'b1;
                    if (cfg.acceleration != 24'd0) begin
                        if (decel) begin
                            spd_next = ({1'b0, spd_reg} < floor_sum) ? SPEED_FLOOR
                                                                      : down_diff[23:0];
                        end else if (spd_reg < cfg.target_speed) begin
                            spd_next = (up_sum > {1'b0, cfg.target_speed}) ?
                                       cfg.target_speed : up_sum[23:0];
                        end
                    end
                    if (delta == 33'd0) begin
                        moving_next = 1'b0;
                        spd_next    = 24'd0;
                    end else begin
                        pulse    = 1'b1;
                        dir      = !delta[32];
                        pos_next = dir ? pos_reg + 32'd1 : pos_reg - 32'd1;
                    end
                end
            end
            FUNC_MOVEABS, FUNC_MOVEREL: begin
                if (enabled_reg) begin
                    tgt_next    = (func_reg == FUNC_MOVEABS) ? value_reg
                                                             : pos_reg + value_reg;
                    moving_next = 1'b1;
                    accepted    = 1'b1;
                end
            end
            FUNC_STOP, FUNC_DISABLE: begin
                if (func_reg == FUNC_DISABLE) begin
                    enabled_next = 1'b0;
                end
                moving_next = 1'b0;
                tgt_next    = pos_reg;
                spd_next    = 24'd0;
                accepted    = 1'b1;
            end
            FUNC_ENABLE: begin
                enabled_next = 1'b1;
                accepted     = 1'b1;
            end
            FUNC_ZERO: begin
                pos_next   = 32'd0;
                homed_next = 1'b1;
                accepted   = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        res_data.accepted   = accepted;
        res_data.step_pulse = pulse;
        res_data.direction  = dir;
        res_data.position   = pos_next;
        res_data.speed      = spd_next;
        res_data.moving     = moving_next;
        res_data.enabled    = enabled_next;
        res_data.homed      = homed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 32'd0;
            tgt_reg     <= 32'd0;
            spd_reg     <= 24'd0;
            moving_reg  <= 1'b0;
            enabled_reg <= 1'b0;
            homed_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                pos_reg     <= pos_next;
                tgt_reg     <= tgt_next;
                spd_reg     <= spd_next;
                moving_reg  <= moving_next;
                enabled_reg <= enabled_next;
                homed_reg   <= homed_next;
            end
        end
    end

    // command and intermediate results
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= s_data.func;
            value_reg <= s_data.value;
        end
        if (mdu_rsp.done) begin
            case (state_reg)
                ST_CHG_MUL: y_reg      <= mdu_rsp.result[39:6];
                ST_RCP_HI:  change_reg <= mdu_rsp.result[44:24];
                ST_REM_MUL: lhs_reg    <= mdu_rsp.result[56:0];
                ST_SPU_MUL: rhs_reg    <= mdu_rsp.result[63:9];
                default: ;
            endcase
        end
    end

endmodule

// File: src/stepper_axis_ramp_stepper_core.sv
// Top level of the stepper axis ramp controller: configuration registers,
// result register, sequencer and shared unit. Depends on stpr_pkg, stpr_mdu, stpr_ctrl.
//
//   channel  | ports                          | beat
//   ---------+--------------------------------+-------------------------------
//   command  | s_valid / s_ready / s_data     | one in_t command
//   result   | m_valid / m_ready / m_data     | one out_t status per command
//   config   | cfg_wr_en / cfg_index / cfg_wdata | one register write, no wait
//
// A tick that runs the ramp update makes six serial passes of the shared 64-bit adder,
// one per multiply and each as long as its LEN_ constant in stpr_pkg, with a hand-off
// state after each, then the result register. Every other command goes straight to the
// result register. One command is in work at a time.
// A finished result waits in the output register; the next command is taken
// while it waits, and the sequencer holds at its last step if it is still full.
// Reset is synchronous, active low; it clears axis state and returns configuration
// to its defaults.
`timescale 1ns / 1ps

module stepper_axis_ramp_stepper_core import stpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    cfg_t     cfg_reg;
    logic     m_valid_reg;
    out_t     m_data_reg;
    logic     res_valid;
    logic     res_ready;
    out_t     res_data;
    mdu_req_t mdu_req;
    mdu_rsp_t mdu_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_speed   <= 24'd0;
            cfg_reg.acceleration   <= 24'd0;
            cfg_reg.steps_per_unit <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET_SPEED: cfg_reg.target_speed   <= cfg_wdata;
                CFG_ACCELERATION: cfg_reg.acceleration   <= cfg_wdata;
                CFG_STEPS_UNIT:   cfg_reg.steps_per_unit <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    stpr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mdu_req   (mdu_req),
        .mdu_rsp   (mdu_rsp)
    );

    stpr_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mdu_req),
        .rsp     (mdu_rsp)
    );

endmodule

// File: src/stpr_chk.sv
// Port-level checker for the stepper axis ramp controller, bound to the top.
// Depends on stpr_pkg and stepper_axis_ramp_stepper_core.
`timescale 1ns / 1ps

module stpr_chk import stpr_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input out_t        m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one command in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command accepted while previous still in work");

    // a step is only issued by an accepted tick of a running move
    a_step_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.step_pulse |-> m_data.accepted && m_data.moving)
        else $error("step pulse without a running move");

    // a disabled axis never reports motion
    a_disabled_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.enabled |-> !m_data.moving)
        else $error("moving while disabled");

endmodule

bind stepper_axis_ramp_stepper_core stpr_chk u_stpr_chk (.*);
